// File: sv/ipv_pkg.sv
// Shared types and constants of the IP address text validator.
`timescale 1ns / 1ps

package ipv_pkg;

  // Address byte counts for IPv6 text.
  localparam logic [4:0] V6_BYTES  = 5'd16;
  localparam logic [4:0] V4_BYTES  = 5'd4;
  localparam logic [4:0] GRP_BYTES = 5'd2;

  // Number of parts in a dotted quad.
  localparam logic [2:0] QUAD_PARTS = 3'd4;

  // Largest value of one decimal part.
  localparam logic [11:0] PART_MAX = 12'd255;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  // Address family codes.
  localparam logic FAMILY_V4 = 1'b0;
  localparam logic FAMILY_V6 = 1'b1;

  // Default queue depths.
  localparam int CLASS_DEPTH_DEF   = 2;
  localparam int VERDICT_DEPTH_DEF = 2;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic       family;
    logic       last;
    logic       is_hex;
    logic       is_dec;
    logic       is_colon;
    logic       is_dot;
    logic [3:0] digit;
  } ipv_class_t;

endpackage

// File: sv/ipv_classify.sv
// Front end: classifies each incoming character of the address text.
`timescale 1ns / 1ps

module ipv_classify import ipv_pkg::*; (
  input  logic [7:0] text_char,
  input  logic       is_last,
  input  logic       family,
  output ipv_class_t item
);

  logic is_dec;
  logic is_lower;
  logic is_upper;

  // Character ranges for decimal and hex digits.
  assign is_dec   = text_char inside {[8'h30:8'h39]};
  assign is_lower = text_char inside {[8'h61:8'h66]};
  assign is_upper = text_char inside {[8'h41:8'h46]};

  // Pack the class of the character with its flags and the mode in force.
  always_comb begin
    item.family   = family;
    item.last     = is_last;
    item.is_dec   = is_dec;
    item.is_hex   = is_dec | is_lower | is_upper;
    item.is_colon = (text_char == CHAR_COLON);
    item.is_dot   = (text_char == CHAR_DOT);
    // Letters a..f and A..F share their low nibble: 1..6 maps to 10..15.
    item.digit    = is_dec ? text_char[3:0] : (text_char[3:0] + 4'd9);
  end

endmodule

// File: sv/ipv_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
`timescale 1ns / 1ps

module ipv_fifo import ipv_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/ipv_parser.sv
// Back end: parses classified characters and forms the verdict on the last one.
`timescale 1ns / 1ps

module ipv_parser import ipv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ipv_class_t item,
  input  logic       item_valid,
  output logic       item_take,
  input  logic       verdict_full,
  output logic       verdict_push,
  output logic       verdict
);

  // Parse phase codes.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_LEAD  = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_TAIL  = 3'd3;
  localparam logic [2:0] PH_FAIL  = 3'd4;

  // Dotted-quad tracker state.
  typedef struct packed {
    logic [8:0] value;
    logic [2:0] count;
    logic       has_digit;
    logic       failed;
  } quad_t;

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  bytes_r, bytes_nxt;
  logic [16:0] grp_r, grp_nxt;
  logic        grp_dig_r, grp_dig_nxt;
  logic        gap_r, gap_nxt;
  quad_t       quad_r, quad_nxt;

  logic        do_body;
  logic [16:0] grp_shift;
  logic [4:0]  n_bytes;
  logic        v6_ok;
  logic        v4_ok;

  // One character through the dotted-quad tracker.
  function automatic quad_t quad_feed(quad_t q, ipv_class_t c);
    quad_t       r;
    logic [11:0] v;
    r = q;
    v = ({3'b0, q.value} << 3) + ({3'b0, q.value} << 1) + {8'b0, c.digit};
    if (!q.failed) begin
      if (c.is_dec) begin
        if (v > PART_MAX) begin
          r.failed = 1'b1;
        end else begin
          r.value = v[8:0];
          if (!q.has_digit) begin
            if (q.count >= QUAD_PARTS) begin
              r.failed = 1'b1;
            end else begin
              r.count     = q.count + 3'd1;
              r.has_digit = 1'b1;
            end
          end
        end
      end else if (c.is_dot && q.has_digit) begin
        if (q.count == QUAD_PARTS) begin
          r.failed = 1'b1;
        end else begin
          r.value     = '0;
          r.has_digit = 1'b0;
        end
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  // A character is taken unless it would need a verdict slot that is busy.
  assign item_take    = item_valid & (~item.last | ~verdict_full);
  assign verdict_push = item_take & item.last;
  assign grp_shift    = {grp_r[12:0], item.digit};

  // Next parse state for the character at the head of the queue.
  always_comb begin
    phase_nxt   = phase_r;
    bytes_nxt   = bytes_r;
    grp_nxt     = grp_r;
    grp_dig_nxt = grp_dig_r;
    gap_nxt     = gap_r;
    quad_nxt    = quad_r;
    do_body     = 1'b0;

    if (item.family == FAMILY_V6) begin
      case (phase_r)
        PH_START: begin
          if (item.is_colon) begin
            phase_nxt = item.last ? PH_FAIL : PH_LEAD;
          end else begin
            phase_nxt = PH_BODY;
            do_body   = 1'b1;
          end
        end
        PH_LEAD: begin
          if (!item.is_colon) begin
            phase_nxt = PH_FAIL;
          end else begin
            phase_nxt = PH_BODY;
            do_body   = 1'b1;
          end
        end
        PH_BODY: begin
          do_body = 1'b1;
        end
        PH_TAIL: begin
          quad_nxt = quad_feed(quad_r, item);
          if (quad_nxt.failed) begin
            phase_nxt = PH_FAIL;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end else begin
      if (phase_r == PH_START) begin
        phase_nxt = PH_BODY;
      end
      quad_nxt = quad_feed(quad_r, item);
    end

    // Body of IPv6 text: hex groups, colons and the start of an IPv4 tail.
    if (do_body) begin
      if (item.is_hex) begin
        grp_nxt = grp_shift;
        if (grp_shift[16]) begin
          phase_nxt = PH_FAIL;
        end else begin
          grp_dig_nxt = 1'b1;
          quad_nxt    = quad_feed(quad_r, item);
        end
      end else if (item.is_colon) begin
        quad_nxt = '0;
        if (!grp_dig_r) begin
          if (gap_r) begin
            phase_nxt = PH_FAIL;
          end else begin
            gap_nxt = 1'b1;
          end
        end else if (item.last || bytes_r > V6_BYTES - GRP_BYTES) begin
          phase_nxt = PH_FAIL;
        end else begin
          bytes_nxt   = bytes_r + GRP_BYTES;
          grp_dig_nxt = 1'b0;
          grp_nxt     = '0;
        end
      end else if (item.is_dot && bytes_r <= V6_BYTES - V4_BYTES) begin
        quad_nxt = quad_feed(quad_r, item);
        if (quad_nxt.failed) begin
          phase_nxt = PH_FAIL;
        end else begin
          bytes_nxt   = bytes_r + V4_BYTES;
          grp_dig_nxt = 1'b0;
          phase_nxt   = PH_TAIL;
        end
      end else begin
        phase_nxt = PH_FAIL;
      end
    end
  end

  // Verdicts on the state after the last character.
  always_comb begin
    n_bytes = bytes_nxt;
    v6_ok   = 1'b1;
    if (phase_nxt == PH_FAIL || phase_nxt == PH_LEAD) begin
      v6_ok = 1'b0;
    end
    if (phase_nxt == PH_TAIL && (quad_nxt.failed || quad_nxt.count != QUAD_PARTS)) begin
      v6_ok = 1'b0;
    end
    if (grp_dig_nxt) begin
      if (n_bytes > V6_BYTES - GRP_BYTES) begin
        v6_ok = 1'b0;
      end else begin
        n_bytes = n_bytes + GRP_BYTES;
      end
    end
    if (gap_nxt) begin
      // The compression must stand for at least one group.
      if (n_bytes == V6_BYTES) begin
        v6_ok = 1'b0;
      end else begin
        n_bytes = V6_BYTES;
      end
    end
    if (n_bytes != V6_BYTES) begin
      v6_ok = 1'b0;
    end
    v4_ok = (phase_nxt != PH_FAIL) && !quad_nxt.failed && (quad_nxt.count == QUAD_PARTS);
  end

  assign verdict = (item.family == FAMILY_V6) ? v6_ok : v4_ok;

  // Parse state; the last character of a string returns it to the start.
  always_ff @(posedge clk) begin
    if (!rst_n || (item_take && item.last)) begin
      phase_r   <= PH_START;
      bytes_r   <= '0;
      grp_r     <= '0;
      grp_dig_r <= 1'b0;
      gap_r     <= 1'b0;
      quad_r    <= '0;
    end else if (item_take) begin
      phase_r   <= phase_nxt;
      bytes_r   <= bytes_nxt;
      grp_r     <= grp_nxt;
      grp_dig_r <= grp_dig_nxt;
      gap_r     <= gap_nxt;
      quad_r    <= quad_nxt;
    end
  end

  // The byte count never runs past a full IPv6 address.
  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= V6_BYTES)
    else $error("parser byte count beyond a full address");

  // A last character leaves the parser at the start of a fresh string.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.last |=> phase_r == PH_START && bytes_r == '0 && !gap_r)
    else $error("parser state not cleared after last character");

  // An IPv4 tail has always accounted for its four bytes.
  a_tail_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TAIL |-> bytes_r >= V4_BYTES && !grp_dig_r)
    else $error("IPv4 tail without its bytes");

endmodule

// File: sv/ip_address_text_validator_unit.sv
// Top level of the IP address text validator.
//
// The address text arrives one character per transfer on in_text_char, with
// in_is_last high on its final character. A character is taken at a rising
// edge with push high and full low. Only the last character of a string
// produces a result: out_address_valid is 1 when the whole string is a valid
// address under the mode of cfg_wdata (0 dotted IPv4, 1 IPv6), which is
// written with cfg_we and resets to IPv6.
// Results are popped with pop while empty is low, oldest first.
// A verdict enters the result queue as the parser takes its last character.
// Characters flow one per cycle, set by the parser step, while the result
// queue has room; a two-entry queue sits between classifier and parser.
// When the receiver stalls, verdicts collect in a two-entry result queue;
// characters keep flowing until a last character finds it full, and then
// full rises once the character queue fills as well.
// Synchronous reset empties both queues and returns the parser to the start
// of a string.
`timescale 1ns / 1ps

module ip_address_text_validator_unit import ipv_pkg::*; #(
  parameter int CLASS_DEPTH   = CLASS_DEPTH_DEF,
  parameter int VERDICT_DEPTH = VERDICT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [7:0] in_text_char,
  input  logic       in_is_last,
  input  logic       push,
  output logic       full,
  output logic       out_address_valid,
  output logic       empty,
  input  logic       pop
);

  logic       family_r;
  ipv_class_t front_item;
  ipv_class_t head_item;
  logic       class_empty;
  logic       head_take;
  logic       verdict_full;
  logic       verdict_push;
  logic       verdict;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r <= FAMILY_V6;
    end else if (cfg_we) begin
      family_r <= cfg_wdata;
    end
  end

  // Front: classify each character under the current mode.
  ipv_classify u_classify (
    .text_char (in_text_char),
    .is_last   (in_is_last),
    .family    (family_r),
    .item      (front_item)
  );

  // Queue of classified characters between front and back.
  ipv_fifo #(
    .WIDTH ($bits(ipv_class_t)),
    .DEPTH (CLASS_DEPTH)
  ) u_class_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (head_take),
    .rdata (head_item),
    .empty (class_empty)
  );

  // Back: parse and judge.
  ipv_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (head_item),
    .item_valid   (~class_empty),
    .item_take    (head_take),
    .verdict_full (verdict_full),
    .verdict_push (verdict_push),
    .verdict      (verdict)
  );

  // Result queue toward the receiver.
  ipv_fifo #(
    .WIDTH (1),
    .DEPTH (VERDICT_DEPTH)
  ) u_verdict_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (verdict_push),
    .wdata (verdict),
    .full  (verdict_full),
    .pop   (pop),
    .rdata (out_address_valid),
    .empty (empty)
  );

endmodule
